/* src/sitl_pkg.sv */
// Shared types and codes for the sorted identifier table lookup block.
// Holds operation, status and match codes, the cell command and the controller state.
// No dependencies.
package sitl_pkg;

    localparam int KEY_W = 32;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_PARENT = 2'd1;
    localparam logic [1:0] KIND_TABLE  = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  tag;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEARCH,
        ST_RESPOND
    } state_t;

endpackage

/* src/sitl_cell.sv */
// One slot of the sorted table: a key and its tag, from a neighbor or the command.
// Depends on sitl_pkg for the cell command struct.
module sitl_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 5
) (
    input  logic                          clk,
    input  sitl_pkg::cell_cmd_t           cmd,
    input  logic [CW-1:0]                 count,
    input  logic [sitl_pkg::KEY_W-1:0]    left_key,
    input  logic [sitl_pkg::KEY_W-1:0]    left_ref,
    input  logic                          left_gt,
    input  logic [sitl_pkg::KEY_W-1:0]    right_key,
    input  logic [sitl_pkg::KEY_W-1:0]    right_ref,
    output logic [sitl_pkg::KEY_W-1:0]    key_q,
    output logic [sitl_pkg::KEY_W-1:0]    ref_q,
    output logic                          gt,
    output logic                          eq
);

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic [sitl_pkg::KEY_W-1:0] key_reg;
    logic [sitl_pkg::KEY_W-1:0] ref_reg;
    logic [sitl_pkg::KEY_W-1:0] key_next;
    logic [sitl_pkg::KEY_W-1:0] ref_next;
    logic                       used;
    logic                       ge;

    assign used = (IDX < count);
    // An empty slot counts as greater, so the insert point is the first marked cell.
    assign gt   = !used || (key_reg > cmd.key);
    assign ge   = used && (key_reg >= cmd.key);
    assign eq   = used && (key_reg == cmd.key);

    always_comb
    begin
        key_next = key_reg;
        ref_next = ref_reg;
        unique case (cmd.op)
            sitl_pkg::CELL_INSERT:
            begin
                if (left_gt)
                begin
                    key_next = left_key;
                    ref_next = left_ref;
                end
                else if (gt)
                begin
                    key_next = cmd.key;
                    ref_next = cmd.tag;
                end
            end
            sitl_pkg::CELL_REMOVE:
            begin
                if (ge)
                begin
                    key_next = right_key;
                    ref_next = right_ref;
                end
            end
            default:
            begin
                key_next = key_reg;
                ref_next = ref_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        ref_reg <= ref_next;
    end

    assign key_q = key_reg;
    assign ref_q = ref_reg;

endmodule

/* src/sitl_chain.sv */
// Row of table cells with neighbor wiring, the match reduction and a read port.
// Depends on sitl_pkg and sitl_cell.
module sitl_chain #(
    parameter int DEPTH = 16,
    parameter int CW    = 5,
    parameter int IW    = 4
) (
    input  logic                          clk,
    input  sitl_pkg::cell_cmd_t           cmd,
    input  logic [CW-1:0]                 count,
    input  logic [IW-1:0]                 rd_idx,
    output logic [sitl_pkg::KEY_W-1:0]    rd_key,
    output logic [sitl_pkg::KEY_W-1:0]    rd_ref,
    output logic                          found
);

    logic [sitl_pkg::KEY_W-1:0] keys [DEPTH];
    logic [sitl_pkg::KEY_W-1:0] refs [DEPTH];
    logic [DEPTH-1:0]           gt_vec;
    logic [DEPTH-1:0]           eq_vec;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [sitl_pkg::KEY_W-1:0] lk;
        logic [sitl_pkg::KEY_W-1:0] lr;
        logic                       lg;
        logic [sitl_pkg::KEY_W-1:0] rk;
        logic [sitl_pkg::KEY_W-1:0] rr;

        if (i == 0)
        begin : g_first
            assign lk = '0;
            assign lr = '0;
            assign lg = 1'b0;
        end
        else
        begin : g_mid_l
            assign lk = keys[i-1];
            assign lr = refs[i-1];
            assign lg = gt_vec[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign rk = keys[i];
            assign rr = refs[i];
        end
        else
        begin : g_mid_r
            assign rk = keys[i+1];
            assign rr = refs[i+1];
        end

        sitl_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .count     (count),
            .left_key  (lk),
            .left_ref  (lr),
            .left_gt   (lg),
            .right_key (rk),
            .right_ref (rr),
            .key_q     (keys[i]),
            .ref_q     (refs[i]),
            .gt        (gt_vec[i]),
            .eq        (eq_vec[i])
        );
    end

    // Keys are sorted, so any match means the first cell at or above the key matches.
    assign found  = |eq_vec;
    assign rd_key = keys[rd_idx];
    assign rd_ref = refs[rd_idx];

endmodule

/* src/sorted_id_table_lookup_unit.sv */
// Sorted identifier table with a last-hit cache: top level and controller.
// Depends on sitl_pkg and sitl_chain.
//
// Usage: an operation (func, key, ref_tag) is transferred on the input channel when
// in_valid is high and in_stall is low. One result (status, match_kind, ref_out,
// entry_count) follows on the output channel for every operation.
// The block works on one operation at a time; in_stall is high from the transfer
// until the result has been moved into the output register.
// Insert, remove, parent lookups, cache hits and unused codes go from ST_EXEC straight
// to ST_RESPOND, which loads the output register and raises out_valid once that
// register is free; the next operation can be transferred once the controller is back
// in ST_IDLE. A lookup that searches the table runs the binary search in ST_SEARCH,
// at most clog2(TABLE_DEPTH)+1 probes, and on a miss a closing ST_SEARCH step that sets
// STATUS_NOT_FOUND. The probe loop does one table read and compare a cycle.
// Insert and remove move every entry above the slot by one cell in the same register update.
// A result waits in the output register while out_stall is high; the next
// operation may be taken meanwhile and then waits for that register to drain.
// The parent identifier is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while idle, the block itself does not enforce this. Reset empties the table, clears
// the cache and the parent identifier, and drops out_valid; table contents are not cleared.
module sorted_id_table_lookup_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [31:0] key,
    input  logic [31:0] ref_tag,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [1:0]  match_kind,
    output logic [31:0] ref_out,
    output logic [4:0]  entry_count
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    sitl_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [31:0]         parent_reg;
    logic                cache_valid_reg, cache_valid_next;
    logic [31:0]         cached_key_reg, cached_key_next;
    logic [31:0]         cached_ref_reg, cached_ref_next;
    logic [1:0]          func_reg, func_next;
    logic [31:0]         item_key_reg, item_key_next;
    logic [31:0]         item_tag_reg, item_tag_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       hi_reg, hi_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic [1:0]          res_kind_reg, res_kind_next;
    logic [31:0]         res_ref_reg, res_ref_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_status_reg, out_status_next;
    logic [1:0]          out_kind_reg, out_kind_next;
    logic [31:0]         out_ref_reg, out_ref_next;
    logic [4:0]          out_count_reg, out_count_next;

    sitl_pkg::cell_cmd_t cmd;
    logic [CW:0]         mid_sum;
    logic [CW-1:0]       mid;
    logic [31:0]         rd_key;
    logic [31:0]         rd_ref;
    logic                found;
    logic [CW+4:0]       count_wide;

    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid        = mid_sum[CW:1];
    assign count_wide = {5'b0, count_reg};

    sitl_chain #(
        .DEPTH (TABLE_DEPTH),
        .CW    (CW),
        .IW    (IW)
    ) u_chain (
        .clk    (clk),
        .cmd    (cmd),
        .count  (count_reg),
        .rd_idx (mid[IW-1:0]),
        .rd_key (rd_key),
        .rd_ref (rd_ref),
        .found  (found)
    );

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        cache_valid_next = cache_valid_reg;
        cached_key_next  = cached_key_reg;
        cached_ref_next  = cached_ref_reg;
        func_next        = func_reg;
        item_key_next    = item_key_reg;
        item_tag_next    = item_tag_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        res_status_next  = res_status_reg;
        res_kind_next    = res_kind_reg;
        res_ref_next     = res_ref_reg;
        out_status_next  = out_status_reg;
        out_kind_next    = out_kind_reg;
        out_ref_next     = out_ref_reg;
        out_count_next   = out_count_reg;
        out_valid_next   = out_valid_reg;
        cmd.op           = sitl_pkg::CELL_HOLD;
        cmd.key          = item_key_reg;
        cmd.tag          = item_tag_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            sitl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next     = func;
                    item_key_next = key;
                    item_tag_next = ref_tag;
                    state_next    = sitl_pkg::ST_EXEC;
                end
            end
            sitl_pkg::ST_EXEC:
            begin
                res_status_next = sitl_pkg::STATUS_OK;
                res_kind_next   = sitl_pkg::KIND_NONE;
                res_ref_next    = '0;
                state_next      = sitl_pkg::ST_RESPOND;
                unique case (func_reg)
                    sitl_pkg::FUNC_INSERT:
                    begin
                        if (count_reg >= DEPTH_C)
                        begin
                            res_status_next = sitl_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            cmd.op     = sitl_pkg::CELL_INSERT;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    sitl_pkg::FUNC_REMOVE:
                    begin
                        if (found)
                        begin
                            cmd.op     = sitl_pkg::CELL_REMOVE;
                            count_next = count_reg - CW'(1);
                            if (cache_valid_reg && (cached_key_reg == item_key_reg))
                            begin
                                cache_valid_next = 1'b0;
                            end
                        end
                        else
                        begin
                            res_status_next = sitl_pkg::STATUS_NOT_FOUND;
                        end
                    end
                    sitl_pkg::FUNC_LOOKUP:
                    begin
                        priority if (item_key_reg == parent_reg)
                        begin
                            cache_valid_next = 1'b0;
                            cached_key_next  = '0;
                            cached_ref_next  = '0;
                            res_kind_next    = sitl_pkg::KIND_PARENT;
                        end
                        else if (cache_valid_reg && (cached_key_reg == item_key_reg))
                        begin
                            res_kind_next = sitl_pkg::KIND_TABLE;
                            res_ref_next  = cached_ref_reg;
                        end
                        else
                        begin
                            lo_next    = '0;
                            hi_next    = count_reg;
                            state_next = sitl_pkg::ST_SEARCH;
                        end
                    end
                    default:
                    begin
                        res_status_next = sitl_pkg::STATUS_OK;
                    end
                endcase
            end
            sitl_pkg::ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    priority if (rd_key == item_key_reg)
                    begin
                        cache_valid_next = 1'b1;
                        cached_key_next  = item_key_reg;
                        cached_ref_next  = rd_ref;
                        res_kind_next    = sitl_pkg::KIND_TABLE;
                        res_ref_next     = rd_ref;
                        state_next       = sitl_pkg::ST_RESPOND;
                    end
                    else if (rd_key < item_key_reg)
                    begin
                        lo_next = mid + CW'(1);
                    end
                    else
                    begin
                        hi_next = mid;
                    end
                end
                else
                begin
                    res_status_next = sitl_pkg::STATUS_NOT_FOUND;
                    state_next      = sitl_pkg::ST_RESPOND;
                end
            end
            sitl_pkg::ST_RESPOND:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_kind_next   = res_kind_reg;
                    out_ref_next    = res_ref_reg;
                    out_count_next  = count_wide[4:0];
                    state_next      = sitl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sitl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= sitl_pkg::ST_IDLE;
            count_reg       <= '0;
            parent_reg      <= '0;
            cache_valid_reg <= 1'b0;
            cached_key_reg  <= '0;
            cached_ref_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            cache_valid_reg <= cache_valid_next;
            cached_key_reg  <= cached_key_next;
            cached_ref_reg  <= cached_ref_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wr_en)
            begin
                parent_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        item_key_reg   <= item_key_next;
        item_tag_reg   <= item_tag_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        res_status_reg <= res_status_next;
        res_kind_reg   <= res_kind_next;
        res_ref_reg    <= res_ref_next;
        out_status_reg <= out_status_next;
        out_kind_reg   <= out_kind_next;
        out_ref_reg    <= out_ref_next;
        out_count_reg  <= out_count_next;
    end

    assign in_stall    = (state_reg != sitl_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign match_kind  = out_kind_reg;
    assign ref_out     = out_ref_reg;
    assign entry_count = out_count_reg;

endmodule

/* src/sitl_checker.sv */
// Port-level checks for the sorted identifier table lookup block, bound to the top level.
// Depends on sitl_pkg for the status and match codes.
module sitl_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [1:0]  match_kind,
    input logic [31:0] ref_out,
    input logic [4:0]  entry_count
);

    // A held result keeps its payload until it is transferred.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(match_kind)
            && $stable(ref_out) && $stable(entry_count))
        else $error("output payload changed while stalled");

    // The controller works on one operation at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted twice in a row");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (TABLE_DEPTH < 32) |-> (int'(entry_count) <= TABLE_DEPTH))
        else $error("entry count above table depth");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == sitl_pkg::STATUS_FULL)
            |-> (match_kind == sitl_pkg::KIND_NONE) && (ref_out == 32'd0))
        else $error("refused insert carries a match");

    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == sitl_pkg::STATUS_NOT_FOUND)
            |-> (match_kind == sitl_pkg::KIND_NONE) && (ref_out == 32'd0))
        else $error("miss carries a match");

endmodule

bind sorted_id_table_lookup_unit sitl_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_sitl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .match_kind  (match_kind),
    .ref_out     (ref_out),
    .entry_count (entry_count)
);

/* tb/tb_sorted_id_table_lookup_unit.sv */
// Self-checking testbench for sorted_id_table_lookup_unit: a directed table, then random
// insert/remove/lookup traffic with parent_id changes, checked against an in-bench model.
// Depends on sitl_pkg and the block's RTL.
module tb_sorted_id_table_lookup_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 16;
    localparam int PHASE_ITEMS = 250;
    localparam int NUM_PHASES = 6;
    localparam int POOL_SIZE = 20;
    localparam int STALL_PCT = 28;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DIR_ROWS = 20;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  kind;
        logic [31:0] tag;
        logic [4:0]  count;
    } op_result_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [31:0] tag;
        logic        fixed;
        op_result_t  want;
    } op_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func = '0;
    logic [31:0] key = '0;
    logic [31:0] ref_tag = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [1:0]  match_kind;
    logic [31:0] ref_out;
    logic [4:0]  entry_count;

    // Model of the table, the last-hit cache and the parent register.
    logic [31:0] id_keys [TABLE_DEPTH];
    logic [31:0] id_tags [TABLE_DEPTH];
    int          id_count;
    logic [31:0] hit_key;
    logic [31:0] hit_tag;
    logic        hit_valid;
    logic [31:0] parent_reg;

    op_result_t  result_q [$];
    op_row_t     directed_ops [DIR_ROWS];
    logic [31:0] key_pool [POOL_SIZE];
    int          fail_count = 0;
    int          idle_cycles = 0;
    bit          steady = 1'b0;

    sorted_id_table_lookup_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .key(key),
        .ref_tag(ref_tag),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .match_kind(match_kind),
        .ref_out(ref_out),
        .entry_count(entry_count)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic op_result_t apply_table_op(input logic [1:0] f, input logic [31:0] k,
                                                  input logic [31:0] t);
        op_result_t r;
        int pos;
        int lo;
        int hi;
        int mid;
        bit done;
        r = '0;
        done = 1'b0;
        case (f)
            sitl_pkg::FUNC_INSERT:
            begin
                if (id_count >= TABLE_DEPTH)
                begin
                    r.status = sitl_pkg::STATUS_FULL;
                end
                else
                begin
                    // Equal keys stay in arrival order: the new one goes after them.
                    pos = 0;
                    while (pos < id_count && id_keys[pos] <= k)
                        pos++;
                    for (int j = id_count; j > pos; j--)
                    begin
                        id_keys[j] = id_keys[j-1];
                        id_tags[j] = id_tags[j-1];
                    end
                    id_keys[pos] = k;
                    id_tags[pos] = t;
                    id_count++;
                    r.status = sitl_pkg::STATUS_OK;
                end
            end
            sitl_pkg::FUNC_REMOVE:
            begin
                r.status = sitl_pkg::STATUS_NOT_FOUND;
                for (int i = 0; i < id_count && !done; i++)
                begin
                    if (id_keys[i] == k)
                    begin
                        for (int j = i + 1; j < id_count; j++)
                        begin
                            id_keys[j-1] = id_keys[j];
                            id_tags[j-1] = id_tags[j];
                        end
                        id_count--;
                        if (hit_valid && hit_key == k)
                            hit_valid = 1'b0;
                        r.status = sitl_pkg::STATUS_OK;
                        done = 1'b1;
                    end
                end
            end
            sitl_pkg::FUNC_LOOKUP:
            begin
                if (k == parent_reg)
                begin
                    hit_valid = 1'b0;
                    hit_key = '0;
                    hit_tag = '0;
                    r.kind = sitl_pkg::KIND_PARENT;
                end
                else if (hit_valid && hit_key == k)
                begin
                    r.kind = sitl_pkg::KIND_TABLE;
                    r.tag = hit_tag;
                end
                else
                begin
                    r.status = sitl_pkg::STATUS_NOT_FOUND;
                    lo = 0;
                    hi = id_count;
                    while (lo < hi && !done)
                    begin
                        mid = (lo + hi) / 2;
                        if (id_keys[mid] == k)
                        begin
                            hit_key = k;
                            hit_tag = id_tags[mid];
                            hit_valid = 1'b1;
                            r.status = sitl_pkg::STATUS_OK;
                            r.kind = sitl_pkg::KIND_TABLE;
                            r.tag = id_tags[mid];
                            done = 1'b1;
                        end
                        else if (id_keys[mid] < k)
                            lo = mid + 1;
                        else
                            hi = mid;
                    end
                end
            end
            default:
            begin
                r.status = sitl_pkg::STATUS_OK;
            end
        endcase
        r.count = id_count[4:0];
        return r;
    endfunction

    // Presents one operation and waits for its transfer; the payload holds while stalled.
    task automatic send_op(input logic [1:0] f, input logic [31:0] k, input logic [31:0] t,
                           input logic fixed, input op_result_t want);
        op_result_t predicted;
        while (!steady && $urandom_range(99) < STALL_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        key <= k;
        ref_tag <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = apply_table_op(f, k, t);
        result_q.push_back(fixed ? want : predicted);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_parent(input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        parent_reg = value;
    endtask

    always @(posedge clk)
    begin
        op_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
            begin
                $error("result transfer with no operation outstanding");
                fail_count++;
            end
            else
            begin
                want = result_q.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fail_count++;
                end
                if (match_kind !== want.kind)
                begin
                    $error("match_kind: expected %0d, got %0d", want.kind, match_kind);
                    fail_count++;
                end
                if (ref_out !== want.tag)
                begin
                    $error("ref_out: expected %h, got %h", want.tag, ref_out);
                    fail_count++;
                end
                if (entry_count !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.count, entry_count);
                    fail_count++;
                end
            end
        end
        out_stall <= !steady && ($urandom_range(99) < STALL_PCT);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] phase_parent [NUM_PHASES];
        int          insert_pct [NUM_PHASES];
        int          pick;
        logic [1:0]  f;
        logic [31:0] k;

        // Rows with a typed result are checked against it; the rest use the model.
        directed_ops = '{
            '{sitl_pkg::FUNC_LOOKUP, 32'h0, 32'h0, 1'b1,
              '{sitl_pkg::STATUS_OK, sitl_pkg::KIND_PARENT, 32'h0, 5'd0}},
            '{sitl_pkg::FUNC_REMOVE, 32'h5, 32'h0, 1'b1,
              '{sitl_pkg::STATUS_NOT_FOUND, sitl_pkg::KIND_NONE, 32'h0, 5'd0}},
            '{sitl_pkg::FUNC_LOOKUP, 32'h5, 32'h0, 1'b1,
              '{sitl_pkg::STATUS_NOT_FOUND, sitl_pkg::KIND_NONE, 32'h0, 5'd0}},
            '{FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              '{sitl_pkg::STATUS_OK, sitl_pkg::KIND_NONE, 32'h0, 5'd0}},
            '{sitl_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              '{sitl_pkg::STATUS_OK, sitl_pkg::KIND_NONE, 32'h0, 5'd1}},
            '{sitl_pkg::FUNC_INSERT, 32'h0, 32'h0, 1'b1,
              '{sitl_pkg::STATUS_OK, sitl_pkg::KIND_NONE, 32'h0, 5'd2}},
            '{sitl_pkg::FUNC_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, 1'b1,
              '{sitl_pkg::STATUS_OK, sitl_pkg::KIND_NONE, 32'h0, 5'd3}},
            '{sitl_pkg::FUNC_INSERT, 32'h8000_0000, 32'h5A5A_5A5A, 1'b1,
              '{sitl_pkg::STATUS_OK, sitl_pkg::KIND_NONE, 32'h0, 5'd4}},
            '{sitl_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1'b1,
              '{sitl_pkg::STATUS_OK, sitl_pkg::KIND_TABLE, 32'hFFFF_FFFF, 5'd4}},
            '{sitl_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1'b1,
              '{sitl_pkg::STATUS_OK, sitl_pkg::KIND_TABLE, 32'hFFFF_FFFF, 5'd4}},
            '{sitl_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, 32'h0, 1'b1,
              '{sitl_pkg::STATUS_OK, sitl_pkg::KIND_NONE, 32'h0, 5'd3}},
            '{sitl_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1'b1,
              '{sitl_pkg::STATUS_NOT_FOUND, sitl_pkg::KIND_NONE, 32'h0, 5'd3}},
            '{sitl_pkg::FUNC_LOOKUP, 32'h8000_0000, 32'h0, 1'b0, '0},
            '{sitl_pkg::FUNC_LOOKUP, 32'h8000_0000, 32'h0, 1'b0, '0},
            '{sitl_pkg::FUNC_LOOKUP, 32'h0, 32'h0, 1'b1,
              '{sitl_pkg::STATUS_OK, sitl_pkg::KIND_PARENT, 32'h0, 5'd3}},
            '{sitl_pkg::FUNC_LOOKUP, 32'h8000_0000, 32'h0, 1'b0, '0},
            '{sitl_pkg::FUNC_REMOVE, 32'h8000_0000, 32'h0, 1'b1,
              '{sitl_pkg::STATUS_OK, sitl_pkg::KIND_NONE, 32'h0, 5'd2}},
            '{sitl_pkg::FUNC_LOOKUP, 32'h8000_0000, 32'h0, 1'b0, '0},
            '{sitl_pkg::FUNC_REMOVE, 32'h8000_0000, 32'h0, 1'b1,
              '{sitl_pkg::STATUS_OK, sitl_pkg::KIND_NONE, 32'h0, 5'd1}},
            '{sitl_pkg::FUNC_REMOVE, 32'h8000_0000, 32'h0, 1'b1,
              '{sitl_pkg::STATUS_NOT_FOUND, sitl_pkg::KIND_NONE, 32'h0, 5'd1}}
        };

        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            id_keys[i] = '0;
            id_tags[i] = '0;
        end
        id_count = 0;
        hit_key = '0;
        hit_tag = '0;
        hit_valid = 1'b0;
        parent_reg = '0;

        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();

        phase_parent = '{32'hFFFF_FFFF, $urandom(), key_pool[3], 32'h0, $urandom(), 32'h1};
        insert_pct = '{50, 35, 65, 25, 45, 40};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_parent(32'h0);

        for (int i = 0; i < DIR_ROWS; i++)
            send_op(directed_ops[i].func, directed_ops[i].key, directed_ops[i].tag,
                    directed_ops[i].fixed, directed_ops[i].want);
        while (id_count < TABLE_DEPTH)
            send_op(sitl_pkg::FUNC_INSERT, $urandom(), $urandom(), 1'b0, '0);
        send_op(sitl_pkg::FUNC_INSERT, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1,
                '{sitl_pkg::STATUS_FULL, sitl_pkg::KIND_NONE, 32'h0, 5'd16});

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // Each parent change waits until every outstanding result has come back.
            drain_results();
            write_parent(phase_parent[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                steady = (p == 2) && (n < 200);
                pick = $urandom_range(99);
                if (pick < 3)
                    f = FUNC_UNUSED;
                else if (pick < 3 + insert_pct[p])
                    f = sitl_pkg::FUNC_INSERT;
                else if (pick < 3 + insert_pct[p] + (97 - insert_pct[p]) / 2)
                    f = sitl_pkg::FUNC_REMOVE;
                else
                    f = sitl_pkg::FUNC_LOOKUP;
                pick = $urandom_range(99);
                if (pick < 70)
                    k = key_pool[$urandom_range(POOL_SIZE - 1)];
                else if (pick < 80)
                    k = parent_reg;
                else
                    k = $urandom();
                send_op(f, k, $urandom(), 1'b0, '0);
            end
        end
        steady = 1'b0;

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sorted_id_table_lookup_unit.f */
src/sitl_pkg.sv
src/sitl_cell.sv
src/sitl_chain.sv
src/sorted_id_table_lookup_unit.sv
src/sitl_checker.sv
tb/tb_sorted_id_table_lookup_unit.sv
